/* hdl/bgps_pkg.sv */
package bgps_pkg;

    // Field widths
    localparam int OP_W     = 2;
    localparam int OFFSET_W = 11;
    localparam int COUNT_W  = 7;
    localparam int DATA_W   = 64;
    localparam int SIZE_W   = 9;
    localparam int POS_W    = OFFSET_W + 1;     // end position incl. carry
    localparam int PTR_W    = OFFSET_W - 3 + 1; // byte pointer incl. span carry
    localparam int SPAN_W   = DATA_W + 8;       // up to nine bytes touched
    localparam int NB_W     = 4;                // byte count per access, 1..9

    localparam int MAX_COUNT       = 64;
    localparam int DEF_MAX_BYTES   = 256;
    localparam int SIZE_RESET      = 256;

    // Opcodes
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ACCESS,
        ST_CLEAR,
        ST_DONE
    } state_t;

    // Low cnt bits set, all ones for cnt of 64 or more
    function automatic logic [DATA_W-1:0] count_mask(input logic [COUNT_W-1:0] cnt);
        logic [DATA_W-1:0] m;
        m = ~({DATA_W{1'b1}} << cnt);
        if (cnt >= COUNT_W'(MAX_COUNT))
        begin
            m = {DATA_W{1'b1}};
        end
        return m;
    endfunction

endpackage

/* hdl/bit_granular_pack_store.sv */
// Bit-addressed byte store.
// Input channel (in_valid/in_ready) carries one request per transaction:
// read bit_count bits from start_bit, write the low bit_count bits of
// write_value at start_bit, or clear the whole store. Each request gives
// exactly one result on the output channel (out_valid/out_ready): read_data
// (zero-extended, zero unless a good read) and status (1 on bad count,
// access past array_bytes*8 capped at MAX_BYTES*8, or unused opcode).
// The cfg channel writes array_bytes; write it only while the block is idle.
// One request at a time. A read or write touches nb = ceil((offset%8+count)/8)
// bytes, 1..9, through the byte-wide RAM. A clear sweeps the RAM one byte per
// cycle. The next request is taken once the block is back in idle, after the
// result is registered.
// After reset the same sweep zeroes the RAM with in_ready low; array_bytes
// resets to 256.
// The result sits in an output register: the next request is accepted while
// it waits, and that request holds its own result until the output is taken.
module bit_granular_pack_store #(
    parameter int MAX_BYTES = bgps_pkg::DEF_MAX_BYTES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bgps_pkg::OP_W-1:0]         opcode,
    input  logic [bgps_pkg::OFFSET_W-1:0]     start_bit,
    input  logic [bgps_pkg::COUNT_W-1:0]      bit_count,
    input  logic [bgps_pkg::DATA_W-1:0]       write_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bgps_pkg::DATA_W-1:0]       read_data,
    output logic                              status,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bgps_pkg::SIZE_W-1:0]       array_bytes
);

    localparam int AW       = $clog2(MAX_BYTES);
    localparam int IW       = (AW > bgps_pkg::PTR_W) ? AW : bgps_pkg::PTR_W;
    localparam int SIZE_MAX = (1 << bgps_pkg::SIZE_W) - 1;
    localparam int SIZE_CAP = (MAX_BYTES < SIZE_MAX) ? MAX_BYTES : SIZE_MAX;

    bgps_pkg::state_t state_reg, state_next;

    logic                              init_reg, init_next;
    logic [bgps_pkg::SIZE_W-1:0]       size_reg;
    logic [bgps_pkg::OP_W-1:0]         op_reg;
    logic [bgps_pkg::OFFSET_W-1:0]     off_reg;
    logic [bgps_pkg::COUNT_W-1:0]      cnt_reg;
    logic [bgps_pkg::DATA_W-1:0]       wval_reg;
    logic                              err_reg, err_next;
    logic [bgps_pkg::NB_W-1:0]         nb_reg, nb_next;
    logic [bgps_pkg::NB_W-1:0]         k_reg, k_next;
    logic [bgps_pkg::NB_W-1:0]         wk_reg, wk_next;
    logic                              rd_pend_reg, rd_pend_next;
    logic [bgps_pkg::SPAN_W-1:0]       acc_reg, acc_next;
    logic [bgps_pkg::SPAN_W-1:0]       dat_reg, dat_next;
    logic [bgps_pkg::SPAN_W-1:0]       msk_reg, msk_next;
    logic [AW-1:0]                     clr_reg, clr_next;
    logic                              out_valid_reg, out_valid_next;
    logic [bgps_pkg::DATA_W-1:0]       rdata_reg, rdata_next;
    logic                              stat_reg, stat_next;

    logic                              in_fire;
    logic                              clr_last;
    logic                              acc_last;
    logic                              out_free;
    logic                              req_ok;
    logic [bgps_pkg::SIZE_W-1:0]       size_use;
    logic [bgps_pkg::POS_W-1:0]        end_pos;
    logic [bgps_pkg::POS_W-1:0]        limit_pos;
    logic [7:0]                        nb_sum;
    logic [bgps_pkg::SPAN_W-1:0]       acc_shift;
    logic [bgps_pkg::DATA_W-1:0]       aligned;
    logic [IW-1:0]                     raddr_w;
    logic [IW-1:0]                     waddr_w;

    logic                              ram_we;
    logic [AW-1:0]                     ram_waddr;
    logic [7:0]                        ram_wdata;
    logic [AW-1:0]                     ram_raddr;
    logic [7:0]                        ram_rdata;

    bgps_ram #(
        .DEPTH (MAX_BYTES),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == bgps_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign clr_last  = (clr_reg == AW'(MAX_BYTES - 1));
    assign acc_last  = rd_pend_reg && (wk_reg == nb_reg - bgps_pkg::NB_W'(1));

    // Range check: the end position against the usable size in bits
    assign size_use  = (size_reg > bgps_pkg::SIZE_W'(SIZE_CAP)) ?
                       bgps_pkg::SIZE_W'(SIZE_CAP) : size_reg;
    assign end_pos   = {1'b0, off_reg} + bgps_pkg::POS_W'(cnt_reg) - bgps_pkg::POS_W'(1);
    assign limit_pos = {size_use, 3'b000};
    assign req_ok    = (cnt_reg != '0)
                    && (cnt_reg <= bgps_pkg::COUNT_W'(bgps_pkg::MAX_COUNT))
                    && (end_pos < limit_pos);
    assign nb_sum    = 8'(off_reg[2:0]) + 8'(cnt_reg) + 8'd7;

    // Byte addresses of the span
    assign raddr_w = IW'(off_reg[bgps_pkg::OFFSET_W-1:3]) + IW'(k_reg);
    assign waddr_w = IW'(off_reg[bgps_pkg::OFFSET_W-1:3]) + IW'(wk_reg);

    // Read alignment
    assign acc_shift = acc_reg >> off_reg[2:0];
    assign aligned   = acc_shift[bgps_pkg::DATA_W-1:0] & bgps_pkg::count_mask(cnt_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bgps_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = bgps_pkg::ST_CHECK;
                end
            end
            bgps_pkg::ST_CHECK:
            begin
                if (op_reg == bgps_pkg::OP_CLEAR)
                begin
                    state_next = bgps_pkg::ST_CLEAR;
                end
                else if ((op_reg == bgps_pkg::OP_READ || op_reg == bgps_pkg::OP_WRITE)
                         && req_ok)
                begin
                    state_next = bgps_pkg::ST_ACCESS;
                end
                else
                begin
                    state_next = bgps_pkg::ST_DONE;
                end
            end
            bgps_pkg::ST_ACCESS:
            begin
                if (acc_last)
                begin
                    state_next = bgps_pkg::ST_DONE;
                end
            end
            bgps_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = init_reg ? bgps_pkg::ST_IDLE : bgps_pkg::ST_DONE;
                end
            end
            bgps_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = bgps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bgps_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        init_next      = init_reg;
        err_next       = err_reg;
        nb_next        = nb_reg;
        k_next         = k_reg;
        wk_next        = wk_reg;
        rd_pend_next   = 1'b0;
        acc_next       = acc_reg;
        dat_next       = dat_reg;
        msk_next       = msk_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        rdata_next     = rdata_reg;
        stat_next      = stat_reg;
        ram_we         = 1'b0;
        ram_waddr      = waddr_w[AW-1:0];
        ram_wdata      = (ram_rdata & ~msk_reg[7:0]) | dat_reg[7:0];
        ram_raddr      = raddr_w[AW-1:0];

        unique case (state_reg)
            bgps_pkg::ST_CHECK:
            begin
                err_next = !((op_reg == bgps_pkg::OP_READ || op_reg == bgps_pkg::OP_WRITE)
                             && req_ok) && (op_reg != bgps_pkg::OP_CLEAR);
                nb_next  = nb_sum[6:3];
                k_next   = '0;
                wk_next  = '0;
                clr_next = '0;
                acc_next = '0;
                dat_next = bgps_pkg::SPAN_W'(wval_reg & bgps_pkg::count_mask(cnt_reg))
                           << off_reg[2:0];
                msk_next = bgps_pkg::SPAN_W'(bgps_pkg::count_mask(cnt_reg)) << off_reg[2:0];
            end
            bgps_pkg::ST_ACCESS:
            begin
                // issue the next byte read
                if (k_reg < nb_reg)
                begin
                    rd_pend_next = 1'b1;
                    k_next       = k_reg + bgps_pkg::NB_W'(1);
                end
                // consume the byte read last cycle
                if (rd_pend_reg)
                begin
                    wk_next = wk_reg + bgps_pkg::NB_W'(1);
                    if (op_reg == bgps_pkg::OP_READ)
                    begin
                        acc_next[8*wk_reg +: 8] = ram_rdata;
                    end
                    else
                    begin
                        ram_we   = 1'b1;
                        dat_next = dat_reg >> 8;
                        msk_next = msk_reg >> 8;
                    end
                end
            end
            bgps_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_last)
                begin
                    init_next = 1'b0;
                    err_next  = 1'b0;
                end
            end
            bgps_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    stat_next      = err_reg;
                    rdata_next     = (!err_reg && op_reg == bgps_pkg::OP_READ) ?
                                     aligned : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bgps_pkg::ST_CLEAR;
            init_reg      <= 1'b1;
            clr_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            size_reg      <= bgps_pkg::SIZE_W'(bgps_pkg::SIZE_RESET);
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            clr_reg       <= clr_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                size_reg <= array_bytes;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg   <= opcode;
            off_reg  <= start_bit;
            cnt_reg  <= bit_count;
            wval_reg <= write_value;
        end
        err_reg   <= err_next;
        nb_reg    <= nb_next;
        k_reg     <= k_next;
        wk_reg    <= wk_next;
        acc_reg   <= acc_next;
        dat_reg   <= dat_next;
        msk_reg   <= msk_next;
        rdata_reg <= rdata_next;
        stat_reg  <= stat_next;
    end

    assign out_valid = out_valid_reg;
    assign read_data = rdata_reg;
    assign status    = stat_reg;

    // Checks
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in progress");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == bgps_pkg::ST_DONE))
        else $error("result raised outside the finishing state");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bgps_pkg::ST_ACCESS |-> k_reg <= nb_reg && wk_reg <= k_reg)
        else $error("byte sequencer ran past the span");

    a_write_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && state_reg == bgps_pkg::ST_ACCESS |-> rd_pend_reg
            && op_reg == bgps_pkg::OP_WRITE)
        else $error("store written without a fresh read of that byte");

endmodule

/* hdl/bgps_ram.sv */
module bgps_ram #(
    parameter int DEPTH = bgps_pkg::DEF_MAX_BYTES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] store_mem [DEPTH];
    logic [7:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= store_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sim/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 6;
    localparam int STORE_BYTES    = bgps_pkg::DEF_MAX_BYTES;
    localparam int CHUNK_ITEMS    = 50;
    localparam int CHUNKS         = 15;
    localparam int LONG_HOLD      = 150;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 4000;

    // opcode left unused by the block, must come back as an error
    localparam logic [bgps_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [bgps_pkg::OP_W-1:0]     op;
        logic [bgps_pkg::OFFSET_W-1:0] offset;
        logic [bgps_pkg::COUNT_W-1:0]  count;
        logic [bgps_pkg::DATA_W-1:0]   value;
    } request_t;

    typedef struct packed {
        logic [bgps_pkg::DATA_W-1:0] data;
        logic                        status;
    } response_t;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          in_valid    = 1'b0;
    logic                          in_ready;
    logic [bgps_pkg::OP_W-1:0]     opcode      = '0;
    logic [bgps_pkg::OFFSET_W-1:0] start_bit   = '0;
    logic [bgps_pkg::COUNT_W-1:0]  bit_count   = '0;
    logic [bgps_pkg::DATA_W-1:0]   write_value = '0;
    logic                          out_valid;
    logic                          out_ready   = 1'b0;
    logic [bgps_pkg::DATA_W-1:0]   read_data;
    logic                          status;
    logic                          cfg_valid   = 1'b0;
    logic                          cfg_ready;
    logic [bgps_pkg::SIZE_W-1:0]   array_bytes = '0;

    // shadow copy of the store and its size register
    logic [7:0]                    shadow_store [STORE_BYTES];
    logic [bgps_pkg::SIZE_W-1:0]   shadow_size;

    request_t            pending_requests[$];
    response_t           predicted_responses[$];

    int unsigned         sender_idle_pct   = 33;
    int unsigned         receiver_idle_pct = 87;
    int unsigned         error_count       = 0;
    int unsigned         responses_seen    = 0;
    int unsigned         hold_left         = 0;
    int unsigned         stall_cycles      = 0;

    bit_granular_pack_store dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .start_bit   (start_bit),
        .bit_count   (bit_count),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_data   (read_data),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .array_bytes (array_bytes)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Expected response of one request; updates the shadow store
    function automatic response_t model_access(input request_t req);
        response_t   r;
        int unsigned used_bytes;
        int unsigned last_pos;
        int unsigned pos;
        r.data   = '0;
        r.status = 1'b0;
        used_bytes = (shadow_size > STORE_BYTES) ? STORE_BYTES : shadow_size;
        last_pos   = int'(req.offset) + int'(req.count) - 1;
        if (req.op == bgps_pkg::OP_CLEAR)
        begin
            for (int b = 0; b < STORE_BYTES; b++)
            begin
                shadow_store[b] = 8'h00;
            end
        end
        else if (req.op != bgps_pkg::OP_READ && req.op != bgps_pkg::OP_WRITE)
        begin
            r.status = 1'b1;
        end
        else if (req.count == 0 || req.count > bgps_pkg::MAX_COUNT
                 || last_pos >= used_bytes * 8)
        begin
            r.status = 1'b1;
        end
        else
        begin
            for (int i = 0; i < int'(req.count); i++)
            begin
                pos = int'(req.offset) + i;
                if (req.op == bgps_pkg::OP_READ)
                    r.data[i] = shadow_store[pos >> 3][pos & 7];
                else
                    shadow_store[pos >> 3][pos & 7] = req.value[i];
            end
        end
        return r;
    endfunction

    // Random request, mostly in range for the given size
    function automatic request_t make_request(input int unsigned size_bytes);
        request_t    req;
        int unsigned used_bytes;
        int unsigned span;
        int unsigned top;
        int unsigned pick;
        used_bytes = (size_bytes > STORE_BYTES) ? STORE_BYTES : size_bytes;
        span       = used_bytes * 8;
        req.value  = {$urandom, $urandom};
        pick       = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0:       req.count = bgps_pkg::COUNT_W'(bgps_pkg::MAX_COUNT);
            1:       req.count = bgps_pkg::COUNT_W'($urandom_range(1, 8));
            default: req.count = bgps_pkg::COUNT_W'($urandom_range(1, bgps_pkg::MAX_COUNT));
        endcase
        if (pick < 45)
            req.op = bgps_pkg::OP_READ;
        else if (pick < 90)
            req.op = bgps_pkg::OP_WRITE;
        else if (pick < 93)
            req.op = bgps_pkg::OP_CLEAR;
        else
        begin
            // noise: any opcode, offset and count
            req.op     = bgps_pkg::OP_W'($urandom_range(0, 3));
            req.offset = bgps_pkg::OFFSET_W'($urandom_range(0, 2047));
            req.count  = bgps_pkg::COUNT_W'($urandom_range(0, 127));
            return req;
        end
        if (span == 0)
        begin
            req.offset = bgps_pkg::OFFSET_W'($urandom_range(0, 2047));
            return req;
        end
        if (span < req.count)
            req.count = bgps_pkg::COUNT_W'(span);
        top = span - req.count;
        // half the time stay in a small window so reads hit written bits
        if ($urandom_range(0, 1) == 0 && top > 127)
            top = 127;
        req.offset = bgps_pkg::OFFSET_W'($urandom_range(0, top));
        return req;
    endfunction

    task automatic queue_request(input logic [bgps_pkg::OP_W-1:0] op,
                                 input int unsigned offset, input int unsigned count,
                                 input logic [bgps_pkg::DATA_W-1:0] value);
        request_t req;
        req.op     = op;
        req.offset = bgps_pkg::OFFSET_W'(offset);
        req.count  = bgps_pkg::COUNT_W'(count);
        req.value  = value;
        pending_requests.push_back(req);
    endtask

    // Wait until every request is accepted and every response taken
    task automatic wait_drained();
        while (pending_requests.size() != 0 || in_valid || predicted_responses.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_size(input int unsigned size_bytes);
        @(posedge clk);
        cfg_valid   <= 1'b1;
        array_bytes <= bgps_pkg::SIZE_W'(size_bytes);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        shadow_size = bgps_pkg::SIZE_W'(size_bytes);
    endtask

    // Request driver
    always @(posedge clk)
    begin
        request_t accepted;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                accepted = pending_requests.pop_front();
                predicted_responses.push_back(model_access(accepted));
            end
            if (!in_valid || in_ready)
            begin
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    in_valid    <= 1'b1;
                    opcode      <= pending_requests[0].op;
                    start_bit   <= pending_requests[0].offset;
                    bit_count   <= pending_requests[0].count;
                    write_value <= pending_requests[0].value;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor and receiver backpressure
    always @(posedge clk)
    begin
        response_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_responses.size() == 0)
                begin
                    $error("response with nothing outstanding: read_data %h status %b",
                           read_data, status);
                    error_count++;
                end
                else
                begin
                    want = predicted_responses.pop_front();
                    if (read_data !== want.data)
                    begin
                        $error("read_data mismatch: expected %h, actual %h", want.data, read_data);
                        error_count++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status mismatch: expected %b, actual %b", want.status, status);
                        error_count++;
                    end
                end
                responses_seen++;
                // long hold-off so the block fills up and stalls its input
                if (responses_seen == 100 || responses_seen == 600)
                    hold_left = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $error("no transaction for %0d cycles", stall_cycles);
            $display("FAILED: results differ");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        int unsigned size_bytes;
        for (int b = 0; b < STORE_BYTES; b++)
        begin
            shadow_store[b] = 8'h00;
        end
        shadow_size = bgps_pkg::SIZE_W'(bgps_pkg::SIZE_RESET);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // full size: extremes, unaligned spans, errors, masking, clear
        write_size(bgps_pkg::SIZE_RESET);
        queue_request(bgps_pkg::OP_READ,  0,    64,  '0);
        queue_request(bgps_pkg::OP_WRITE, 0,    64,  '1);
        queue_request(bgps_pkg::OP_READ,  0,    64,  '0);
        queue_request(bgps_pkg::OP_WRITE, 2047, 1,   64'd1);
        queue_request(bgps_pkg::OP_READ,  2047, 1,   '0);
        queue_request(bgps_pkg::OP_WRITE, 2040, 9,   '1);
        queue_request(bgps_pkg::OP_READ,  1984, 64,  '0);
        queue_request(bgps_pkg::OP_WRITE, 3,    64,  {$urandom, $urandom});
        queue_request(bgps_pkg::OP_READ,  3,    64,  '0);
        queue_request(bgps_pkg::OP_READ,  0,    0,   '0);
        queue_request(bgps_pkg::OP_WRITE, 100,  0,   '1);
        queue_request(bgps_pkg::OP_READ,  0,    65,  '0);
        queue_request(bgps_pkg::OP_WRITE, 0,    127, '1);
        queue_request(OP_UNUSED,          0,    8,   '1);
        queue_request(bgps_pkg::OP_READ,  2047, 64,  '0);
        queue_request(bgps_pkg::OP_CLEAR, 2047, 127, {$urandom, $urandom});
        queue_request(bgps_pkg::OP_READ,  0,    64,  '0);
        queue_request(bgps_pkg::OP_WRITE, 13,   3,   '1);
        queue_request(bgps_pkg::OP_READ,  8,    16,  '0);
        queue_request(bgps_pkg::OP_READ,  1984, 64,  '0);
        wait_drained();

        // size zero: every access fails, clear still succeeds
        write_size(0);
        queue_request(bgps_pkg::OP_READ,  0, 1, '0);
        queue_request(bgps_pkg::OP_WRITE, 0, 1, '1);
        queue_request(bgps_pkg::OP_CLEAR, 0, 0, '0);
        wait_drained();

        // size above the store saturates
        write_size(300);
        queue_request(bgps_pkg::OP_WRITE, 2047, 1, 64'd1);
        queue_request(bgps_pkg::OP_READ,  2040, 8, '0);
        wait_drained();

        // one byte in use
        write_size(1);
        queue_request(bgps_pkg::OP_WRITE, 0, 8, {$urandom, $urandom});
        queue_request(bgps_pkg::OP_READ,  1, 8, '0);
        queue_request(bgps_pkg::OP_READ,  7, 1, '0);
        wait_drained();

        // random chunks, each with its own size, three idling phases
        for (int chunk = 0; chunk < CHUNKS; chunk++)
        begin
            if (chunk == CHUNKS / 3)
            begin
                sender_idle_pct   = 87;
                receiver_idle_pct = 33;
            end
            else if (chunk == 2 * CHUNKS / 3)
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: size_bytes = STORE_BYTES;
                4:          size_bytes = STORE_BYTES - 1;
                5:          size_bytes = $urandom_range(1, 16);
                6, 7:       size_bytes = $urandom_range(1, STORE_BYTES);
                8:          size_bytes = $urandom_range(STORE_BYTES + 1, 511);
                default:    size_bytes = 0;
            endcase
            if (chunk == 0)
                size_bytes = STORE_BYTES;
            write_size(size_bytes);
            for (int n = 0; n < CHUNK_ITEMS; n++)
            begin
                pending_requests.push_back(make_request(size_bytes));
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
